// ----- src/isfa_pkg.sv -----
`timescale 1ns / 1ps

package isfa_pkg;

  localparam int GAIN_W              = 24;
  localparam int FORCE_W             = 48;
  localparam int ROOT_FRAC           = 16;
  localparam int POSITION_BITS_DEF   = 24;
  localparam int FORCE_FRAC_BITS_DEF = 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd22788;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SQUARE,
    ST_CHECK,
    ST_NUMER,
    ST_ROOT,
    ST_MULT,
    ST_DIVIDE,
    ST_ACCUM,
    ST_FINISH
  } isfa_state_t;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic       numer;
    logic [1:0] axis;
    logic       zero_mark;
    logic       root_init;
    logic       root_step;
    logic       mul_step;
    logic       div_step;
    logic       accum;
    logic       emit;
  } isfa_cmd_t;

  typedef struct packed {
    logic present;
    logic last;
    logic s_zero;
    logic out_blocked;
  } isfa_stat_t;

endpackage

// ----- src/isfa_ctrl.sv -----
`timescale 1ns / 1ps

module isfa_ctrl import isfa_pkg::*; #(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int FORCE_FRAC_BITS = FORCE_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output isfa_cmd_t  cmd,
  input  isfa_stat_t stat
);

  localparam int RB   = POSITION_BITS + 1 + ROOT_FRAC;
  localparam int QB   = GAIN_W + FORCE_FRAC_BITS;
  localparam int MAXS = (RB > QB) ? RB : QB;
  localparam int CW   = $clog2(MAXS + 1);

  isfa_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + CW'(1);
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = cnt_r[1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_nxt   = '0;
        state_nxt = stat.present ? ST_SQUARE : ST_FINISH;
      end
      ST_SQUARE: begin
        cmd.sq = 1'b1;
        if (cnt_r == CW'(2)) begin
          cnt_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_nxt = '0;
        if (stat.s_zero) begin
          cmd.zero_mark = 1'b1;
          state_nxt     = ST_FINISH;
        end else begin
          cmd.root_init = 1'b1;
          state_nxt     = ST_NUMER;
        end
      end
      ST_NUMER: begin
        cmd.numer = 1'b1;
        if (cnt_r == CW'(2)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CW'(RB - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CW'(RB - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CW'(QB - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cnt_nxt = '0;
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_blocked) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/isfa_dp.sv -----
`timescale 1ns / 1ps

module isfa_dp import isfa_pkg::*; #(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int FORCE_FRAC_BITS = FORCE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [GAIN_W-1:0]               cfg_force_gain,
  input  logic signed [POSITION_BITS-1:0] in_object_x,
  input  logic signed [POSITION_BITS-1:0] in_object_y,
  input  logic signed [POSITION_BITS-1:0] in_object_z,
  input  logic signed [POSITION_BITS-1:0] in_target_x,
  input  logic signed [POSITION_BITS-1:0] in_target_y,
  input  logic signed [POSITION_BITS-1:0] in_target_z,
  input  logic                            in_object_present,
  input  logic                            in_last_of_tick,
  input  isfa_cmd_t                       cmd,
  output isfa_stat_t                      stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [FORCE_W-1:0]       out_force_x,
  output logic signed [FORCE_W-1:0]       out_force_y,
  output logic signed [FORCE_W-1:0]       out_force_z,
  output logic                            out_zero_distance_seen,
  output logic                            out_saturated
);

  localparam int DW = POSITION_BITS + 1;
  localparam int BW = (DW > GAIN_W) ? DW : GAIN_W;
  localparam int PW = DW + BW;
  localparam int SB = 2 * DW;
  localparam int XB = SB + 2 * ROOT_FRAC;
  localparam int RB = XB / 2;
  localparam int MB = GAIN_W + DW;
  localparam int NB = MB + FORCE_FRAC_BITS + ROOT_FRAC;
  localparam int QB = GAIN_W + FORCE_FRAC_BITS;
  localparam int DB = SB + RB;
  localparam int AW = FORCE_W + 2;
  localparam logic signed [AW-1:0] SUM_MAX = {3'b000, {(FORCE_W-1){1'b1}}};
  localparam logic signed [AW-1:0] SUM_MIN = {3'b111, {(FORCE_W-1){1'b0}}};

  logic [GAIN_W-1:0]  gain_r;
  logic [DW-1:0]      mag_r [3];
  logic               neg_r [3];
  logic               present_r, last_r;
  logic [SB-1:0]      s_r;
  logic [XB-1:0]      x_r;
  logic [RB:0]        sq_rem_r;
  logic [RB-1:0]      root_r;
  logic [DB-1:0]      mcand_r, prod_r;
  logic [DB-1:0]      rem_r [3];
  logic [QB-1:0]      ql_r [3];
  logic signed [FORCE_W-1:0] acc_r [3];
  logic               zf_r, sf_r, out_valid_r;

  logic signed [DW-1:0] dx_w [3];
  logic [DW-1:0]        dmag_w [3];
  logic [PW-1:0]        mul_p;
  logic [NB-1:0]        num_w;
  logic [RB+2:0]        rsh_w, trial_w;
  logic                 rge_w;
  logic [DB:0]          dsh_w [3];
  logic                 dge_w [3];
  logic signed [AW-1:0] qs_w [3], sum_w [3];
  logic signed [FORCE_W-1:0] accn_w [3];
  logic                 clip_w [3];

  always_comb begin
    dx_w[0] = DW'(in_object_x) - DW'(in_target_x);
    dx_w[1] = DW'(in_object_y) - DW'(in_target_y);
    dx_w[2] = DW'(in_object_z) - DW'(in_target_z);
    for (int k = 0; k < 3; k++) begin
      dmag_w[k] = dx_w[k][DW-1] ? DW'(~dx_w[k] + DW'(1)) : DW'(dx_w[k]);
    end
  end

  // One shared multiplier: squares first, then gain times magnitude.
  always_comb begin
    mul_p = PW'(mag_r[cmd.axis]) *
            (cmd.sq ? PW'(mag_r[cmd.axis]) : PW'(gain_r));
    num_w = {mul_p[MB-1:0], {(FORCE_FRAC_BITS + ROOT_FRAC){1'b0}}};
  end

  always_comb begin
    rsh_w   = {sq_rem_r, x_r[XB-1 -: 2]};
    trial_w = (RB+3)'({root_r, 2'b01});
    rge_w   = rsh_w >= trial_w;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh_w[k]  = {rem_r[k], ql_r[k][QB-1]};
      dge_w[k]  = dsh_w[k] >= {1'b0, prod_r};
      qs_w[k]   = $signed({{(AW-QB){1'b0}}, ql_r[k]});
      if (neg_r[k]) begin
        qs_w[k] = -qs_w[k];
      end
      sum_w[k]  = AW'(acc_r[k]) + qs_w[k];
      clip_w[k] = 1'b1;
      if (sum_w[k] > SUM_MAX) begin
        accn_w[k] = FORCE_W'(SUM_MAX);
      end else if (sum_w[k] < SUM_MIN) begin
        accn_w[k] = FORCE_W'(SUM_MIN);
      end else begin
        accn_w[k] = FORCE_W'(sum_w[k]);
        clip_w[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= dmag_w[k];
        neg_r[k] <= dx_w[k][DW-1];
      end
      present_r <= in_object_present;
      last_r    <= in_last_of_tick;
      s_r       <= '0;
    end
    if (cmd.sq) begin
      s_r <= s_r + SB'(mul_p);
    end
    if (cmd.numer) begin
      rem_r[cmd.axis] <= DB'(num_w[NB-1:QB]);
      ql_r[cmd.axis]  <= num_w[QB-1:0];
    end
    if (cmd.root_init) begin
      x_r      <= {s_r, {(2*ROOT_FRAC){1'b0}}};
      sq_rem_r <= '0;
      root_r   <= '0;
      mcand_r  <= DB'(s_r);
      prod_r   <= '0;
    end else if (cmd.root_step) begin
      sq_rem_r <= rge_w ? (RB+1)'(rsh_w - trial_w) : (RB+1)'(rsh_w);
      root_r   <= {root_r[RB-2:0], rge_w};
      x_r      <= x_r << 2;
    end else if (cmd.mul_step) begin
      prod_r  <= prod_r + (root_r[0] ? mcand_r : '0);
      mcand_r <= mcand_r << 1;
      root_r  <= root_r >> 1;
    end
    if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= dge_w[k] ? DB'(dsh_w[k] - {1'b0, prod_r}) : DB'(dsh_w[k]);
        ql_r[k]  <= {ql_r[k][QB-2:0], dge_w[k]};
      end
    end
    if (cmd.emit) begin
      out_force_x            <= acc_r[0];
      out_force_y            <= acc_r[1];
      out_force_z            <= acc_r[2];
      out_zero_distance_seen <= zf_r;
      out_saturated          <= sf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      zf_r        <= 1'b0;
      sf_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        gain_r <= cfg_force_gain;
      end
      if (cmd.zero_mark) begin
        zf_r <= 1'b1;
      end
      if (cmd.accum) begin
        for (int k = 0; k < 3; k++) begin
          acc_r[k] <= accn_w[k];
        end
        sf_r <= sf_r | clip_w[0] | clip_w[1] | clip_w[2];
      end
      if (cmd.emit) begin
        for (int k = 0; k < 3; k++) begin
          acc_r[k] <= '0;
        end
        zf_r        <= 1'b0;
        sf_r        <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.present     = present_r;
    stat.last        = last_r;
    stat.s_zero      = (s_r == '0);
    stat.out_blocked = out_valid_r & ~out_ready;
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result loaded over an untaken result");
  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> last_r)
    else $error("result emitted for an item not closing its tick");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0 && !zf_r && !sf_r))
    else $error("tick state not cleared after result");
  a_zero_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.zero_mark |-> (s_r == '0 && present_r))
    else $error("zero distance flagged for a non-zero distance");
`endif

endmodule

// ----- src/inverse_square_force_accumulator.sv -----
`timescale 1ns / 1ps

// Inverse-square force accumulator.
// Input channel (in_valid/in_ready): one item per object, carrying the object and
// target positions, a present bit and a last-of-tick mark. A present object adds
// force_gain * d / |d|^3 to the three-axis Q31.16 accumulator, with saturation.
// A present object on the target adds nothing and sets the zero-distance flag.
// Result channel (out_valid/out_ready): one item for each item marked last of
// tick, carrying the accumulated force and the tick flags, after which the
// accumulator and flags clear.
// Configuration (cfg_valid/cfg_ready): writes force_gain; always ready and only
// to be written while the block is idle.
// Timing: one item at a time. A present, non-zero item spends its time mostly in
// the bit-serial square root, the shift-add product of s and the root, and the
// bit-serial division, each one bit a cycle. Absent and zero-distance items skip
// these steps. At the end of a tick the result is loaded into the output register.
// When the receiver stalls, the result waits in its output register and the next
// item is still taken and worked on; only a second tick end waits for the first.
// Reset clears the accumulator and flags and restores force_gain to 22788.

module inverse_square_force_accumulator import isfa_pkg::*; #(
  parameter int POSITION_BITS   = POSITION_BITS_DEF,
  parameter int FORCE_FRAC_BITS = FORCE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [GAIN_W-1:0]               cfg_force_gain,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [POSITION_BITS-1:0] in_object_x,
  input  logic signed [POSITION_BITS-1:0] in_object_y,
  input  logic signed [POSITION_BITS-1:0] in_object_z,
  input  logic signed [POSITION_BITS-1:0] in_target_x,
  input  logic signed [POSITION_BITS-1:0] in_target_y,
  input  logic signed [POSITION_BITS-1:0] in_target_z,
  input  logic                            in_object_present,
  input  logic                            in_last_of_tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [FORCE_W-1:0]       out_force_x,
  output logic signed [FORCE_W-1:0]       out_force_y,
  output logic signed [FORCE_W-1:0]       out_force_z,
  output logic                            out_zero_distance_seen,
  output logic                            out_saturated
);

  isfa_cmd_t  cmd;
  isfa_stat_t stat;

  // The gain register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  isfa_ctrl #(
    .POSITION_BITS  (POSITION_BITS),
    .FORCE_FRAC_BITS(FORCE_FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  isfa_dp #(
    .POSITION_BITS  (POSITION_BITS),
    .FORCE_FRAC_BITS(FORCE_FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_force_gain        (cfg_force_gain),
    .in_object_x           (in_object_x),
    .in_object_y           (in_object_y),
    .in_object_z           (in_object_z),
    .in_target_x           (in_target_x),
    .in_target_y           (in_target_y),
    .in_target_z           (in_target_z),
    .in_object_present     (in_object_present),
    .in_last_of_tick       (in_last_of_tick),
    .cmd                   (cmd),
    .stat                  (stat),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_force_x           (out_force_x),
    .out_force_y           (out_force_y),
    .out_force_z           (out_force_z),
    .out_zero_distance_seen(out_zero_distance_seen),
    .out_saturated         (out_saturated)
  );

endmodule

// ----- verif/tb_inverse_square_force_accumulator.sv -----
`timescale 1ns / 1ps

module tb_inverse_square_force_accumulator;
  import isfa_pkg::*;

  localparam int POS_W       = POSITION_BITS_DEF;
  localparam int FRAC_W      = FORCE_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  // Time to wait when the last object of a phase carried no tick end, so that
  // an item still in flight inside the block can finish.
  localparam int DRAIN_CYCLES = 400;
  localparam longint ACC_MAX = 64'sd140737488355327;
  localparam longint ACC_MIN = -64'sd140737488355328;
  localparam logic [63:0] TERM_CLIP = 64'd281474976710656;

  typedef struct packed {
    logic [POS_W-1:0] ox, oy, oz, tx, ty, tz;
    logic             present;
    logic             last;
  } object_item_t;

  typedef struct packed {
    logic [FORCE_W-1:0] fx, fy, fz;
    logic               zero_seen;
    logic               sat;
  } tick_force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [GAIN_W-1:0]   cfg_force_gain = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  object_item_t        cur_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [FORCE_W-1:0] out_force_x, out_force_y, out_force_z;
  logic                out_zero_distance_seen, out_saturated;

  inverse_square_force_accumulator u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_force_gain         (cfg_force_gain),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_object_x            (cur_item.ox),
    .in_object_y            (cur_item.oy),
    .in_object_z            (cur_item.oz),
    .in_target_x            (cur_item.tx),
    .in_target_y            (cur_item.ty),
    .in_target_z            (cur_item.tz),
    .in_object_present      (cur_item.present),
    .in_last_of_tick        (cur_item.last),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_force_x            (out_force_x),
    .out_force_y            (out_force_y),
    .out_force_z            (out_force_z),
    .out_zero_distance_seen (out_zero_distance_seen),
    .out_saturated          (out_saturated)
  );

  // Objects waiting to be sent, and the tick forces we expect back.
  object_item_t pending_objects[$];
  tick_force_t  expected_ticks[$];

  // The predictor's own copy of the block state and its gain register.
  logic [GAIN_W-1:0]         model_gain;
  logic signed [FORCE_W-1:0] model_force[3];
  logic                      model_zero_flag;
  logic                      model_sat_flag;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int ticks_checked = 0;
  int sat_ticks = 0;
  int zero_ticks = 0;
  int objects_sent = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root of a 128-bit value, one result bit per pass.
  function automatic logic [127:0] int_sqrt(logic [127:0] x);
    logic [127:0] res;
    logic [127:0] b;
    res = '0;
    b = 128'd1 << 126;
    while (b != 0 && b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Works out the effect of one accepted object and, on a tick end, queues the
  // force that the block must report.
  task automatic predict_object(object_item_t it);
    logic [POS_W+1:0] d[3];
    logic [POS_W+1:0] absd;
    logic [127:0]     s, root, num, q;
    logic [63:0]      qm;
    longint           sum;
    tick_force_t      res;
    if (it.present) begin
      d[0] = {{2{it.ox[POS_W-1]}}, it.ox} - {{2{it.tx[POS_W-1]}}, it.tx};
      d[1] = {{2{it.oy[POS_W-1]}}, it.oy} - {{2{it.ty[POS_W-1]}}, it.ty};
      d[2] = {{2{it.oz[POS_W-1]}}, it.oz} - {{2{it.tz[POS_W-1]}}, it.tz};
      s = '0;
      for (int k = 0; k < 3; k++) begin
        absd = d[k][POS_W+1] ? -d[k] : d[k];
        s = s + 128'(absd) * 128'(absd);
      end
      if (s == 0) begin
        model_zero_flag = 1'b1;
      end else begin
        root = int_sqrt(s << (2 * ROOT_FRAC));
        for (int k = 0; k < 3; k++) begin
          absd = d[k][POS_W+1] ? -d[k] : d[k];
          num = (128'(model_gain) * 128'(absd)) << (FRAC_W + ROOT_FRAC);
          q = num / (s * root);
          qm = (q > 128'(TERM_CLIP)) ? TERM_CLIP : q[63:0];
          sum = longint'(model_force[k]) +
                (d[k][POS_W+1] ? -longint'(qm) : longint'(qm));
          if (sum > ACC_MAX) begin
            sum = ACC_MAX;
            model_sat_flag = 1'b1;
          end
          if (sum < ACC_MIN) begin
            sum = ACC_MIN;
            model_sat_flag = 1'b1;
          end
          model_force[k] = sum[FORCE_W-1:0];
        end
      end
    end
    if (it.last) begin
      res.fx = model_force[0];
      res.fy = model_force[1];
      res.fz = model_force[2];
      res.zero_seen = model_zero_flag;
      res.sat = model_sat_flag;
      expected_ticks.push_back(res);
      for (int k = 0; k < 3; k++) model_force[k] = '0;
      model_zero_flag = 1'b0;
      model_sat_flag = 1'b0;
    end
  endtask

  task automatic check_field(string name, logic [FORCE_W-1:0] exp_v,
                             logic [FORCE_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // Driver: presents the next pending object once the current one is taken.
  // The predictor runs on the item at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_object(cur_item);
        objects_sent++;
      end
      if (pending_objects.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        cur_item <= pending_objects.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted tick force against the oldest expectation
  // and throttles the result channel.
  always @(posedge clk) begin
    tick_force_t exp_t;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected tick force, expected none, got %h %h %h", $time,
                 out_force_x, out_force_y, out_force_z);
      end else begin
        exp_t = expected_ticks.pop_front();
        check_field("force_x", exp_t.fx, out_force_x);
        check_field("force_y", exp_t.fy, out_force_y);
        check_field("force_z", exp_t.fz, out_force_z);
        check_field("zero_distance_seen", 48'(exp_t.zero_seen), 48'(out_zero_distance_seen));
        check_field("saturated", 48'(exp_t.sat), 48'(out_saturated));
        ticks_checked++;
        if (exp_t.sat) sat_ticks++;
        if (exp_t.zero_seen) zero_ticks++;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d ticks still expected", cycle_count,
               expected_ticks.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  // Builds one object: far apart, close together, coincident or a mid-range
  // separation, chosen at random.
  function automatic object_item_t make_object(logic last);
    object_item_t it;
    int kind;
    kind = $urandom_range(9);
    it.tx = rand_pos();
    it.ty = rand_pos();
    it.tz = rand_pos();
    if (kind < 3) begin
      it.ox = rand_pos();
      it.oy = rand_pos();
      it.oz = rand_pos();
    end else if (kind < 7) begin
      it.ox = it.tx + POS_W'($urandom_range(2000) - 1000);
      it.oy = it.ty + POS_W'($urandom_range(2000) - 1000);
      it.oz = it.tz + POS_W'($urandom_range(2000) - 1000);
    end else if (kind < 8) begin
      it.ox = it.tx;
      it.oy = it.ty;
      it.oz = it.tz;
    end else begin
      it.ox = it.tx + POS_W'($urandom_range(131072) - 65536);
      it.oy = it.ty + POS_W'($urandom_range(131072) - 65536);
      it.oz = it.tz + POS_W'($urandom_range(131072) - 65536);
    end
    it.present = ($urandom_range(99) >= 15);
    it.last = last;
    return it;
  endfunction

  // Queues whole ticks of one to six objects, with some loose objects whose
  // marks are random as noise, until about n objects are waiting.
  task automatic queue_random_ticks(int n);
    int added;
    int len;
    object_item_t it;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 10) begin
        it = make_object(1'($urandom_range(1)));
        it.present = 1'($urandom_range(1));
        pending_objects.push_back(it);
        added++;
      end else begin
        len = $urandom_range(6, 1);
        for (int j = 0; j < len; j++) pending_objects.push_back(make_object(j == len - 1));
        added += len;
      end
    end
  endtask

  // A long tick of objects one unit from the target along one axis, which at
  // high gain drives that accumulator component into its clip.
  task automatic queue_saturating_tick(logic neg, int len);
    object_item_t it;
    for (int j = 0; j < len; j++) begin
      it = '0;
      it.tx = rand_pos();
      it.ty = rand_pos();
      it.tz = rand_pos();
      it.ox = neg ? it.tx - POS_W'(1) : it.tx + POS_W'(1);
      it.oy = it.ty;
      it.oz = it.tz;
      it.present = 1'b1;
      it.last = (j == len - 1);
      pending_objects.push_back(it);
    end
  endtask

  task automatic queue_object(logic [POS_W-1:0] ox, oy, oz, tx, ty, tz,
                              logic present, logic last);
    object_item_t it;
    it = '{ox, oy, oz, tx, ty, tz, present, last};
    pending_objects.push_back(it);
  endtask

  // Waits until every queued object has gone and every tick force has come
  // back, then lets any object without a tick end finish inside the block.
  task automatic wait_until_idle();
    while (pending_objects.size() > 0 || in_valid || expected_ticks.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [GAIN_W-1:0] gain);
    cfg_valid <= 1'b1;
    cfg_force_gain <= gain;
    do @(posedge clk); while (!cfg_ready);
    model_gain = gain;
    cfg_valid <= 1'b0;
  endtask

  localparam logic [POS_W-1:0] P_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] P_MIN = {1'b1, {(POS_W-1){1'b0}}};

  initial begin
    model_gain = GAIN_RESET;
    for (int k = 0; k < 3; k++) model_force[k] = '0;
    model_zero_flag = 1'b0;
    model_sat_flag = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset gain, with the sender idling more lightly.
    send_idle_pct = 29;
    recv_idle_pct = 69;
    // Largest separations in both directions, each as a one-object tick.
    queue_object(P_MAX, P_MAX, P_MAX, P_MIN, P_MIN, P_MIN, 1'b1, 1'b1);
    queue_object(P_MIN, P_MIN, P_MIN, P_MAX, P_MAX, P_MAX, 1'b1, 1'b1);
    queue_object(P_MAX, '0, P_MIN, P_MIN, '0, P_MAX, 1'b1, 1'b1);
    // Unit separations on each axis and one object on the target.
    queue_object(24'd1, '0, '0, '0, '0, '0, 1'b1, 1'b0);
    queue_object('0, -24'sd1, '0, '0, '0, '0, 1'b1, 1'b0);
    queue_object(P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, P_MIN, 1'b1, 1'b0);
    queue_object('0, '0, 24'd1, '0, '0, '0, 1'b1, 1'b1);
    // An absent object, both alone and ending a tick; an absent object on the
    // target must not raise the zero-distance flag.
    queue_object(24'd5, 24'd5, 24'd5, '0, '0, '0, 1'b0, 1'b0);
    queue_object(24'd3, 24'd4, '0, '0, '0, '0, 1'b1, 1'b0);
    queue_object('0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
    // A tick with nothing present, and one with only a coincident object.
    queue_object(P_MAX, P_MIN, P_MAX, '0, '0, '0, 1'b0, 1'b1);
    queue_object(P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, 1'b1, 1'b1);
    // Wrap of position arithmetic near the extremes, and moderate distances.
    queue_object(P_MAX, 24'd100, -24'sd100, P_MAX - 24'd7, 24'd0, 24'd0, 1'b1, 1'b0);
    queue_object(24'd1000, 24'd2000, 24'd3000, -24'sd1000, 24'd0, 24'd5, 1'b1, 1'b1);
    wait_until_idle();

    // Full gain, with a saturating tick in each direction among random ticks.
    write_gain({GAIN_W{1'b1}});
    queue_saturating_tick(1'b0, 140);
    queue_random_ticks(300);
    queue_saturating_tick(1'b1, 140);
    queue_random_ticks(300);
    wait_until_idle();

    // Now the receiver idles more lightly; zero gain first, then a random one.
    send_idle_pct = 69;
    recv_idle_pct = 29;
    write_gain('0);
    queue_random_ticks(200);
    wait_until_idle();
    write_gain(GAIN_W'($urandom));
    queue_random_ticks(450);
    wait_until_idle();

    // Back to the reset value, with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(GAIN_RESET);
    queue_random_ticks(360);
    wait_until_idle();

    $display("Sent %0d objects and checked %0d tick forces over five gain settings.",
             objects_sent, ticks_checked);
    $display("%0d ticks saw a clipped component, %0d saw an object on the target.",
             sat_ticks, zero_ticks);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/isfa_pkg.sv
src/isfa_ctrl.sv
src/isfa_dp.sv
src/inverse_square_force_accumulator.sv
verif/tb_inverse_square_force_accumulator.sv
